/* hdl/ilid_pkg.sv */
package ilid_pkg;

    // Fixed field widths
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    // Default list capacity
    localparam int DEF_CAPACITY = 64;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_LOCATE = 2'd3
    } t_mode;

    // Control states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    // Shift command broadcast to every cell in the accept cycle
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [POS_W-1:0]         p0;
        logic signed [DATA_W-1:0] value;
    } t_shift_cmd;

    // Query held for the length of a sweep
    typedef struct packed {
        logic                     get_ok;
        logic                     locate;
        logic [POS_W-1:0]         p0;
        logic signed [DATA_W-1:0] value;
    } t_query;

    // Partial answer handed from cell to cell
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] rd;
    } t_sweep;

endpackage

/* hdl/ilid_in_if.sv */
interface ilid_in_if;
    logic                                    valid;
    logic                                    ready;
    ilid_pkg::t_mode                         mode;
    logic [ilid_pkg::POS_W-1:0]              position;
    logic signed [ilid_pkg::DATA_W-1:0]      value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);
endinterface

/* hdl/ilid_out_if.sv */
interface ilid_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    status;
    logic signed [ilid_pkg::DATA_W-1:0]      read_value;
    logic [ilid_pkg::LEN_W-1:0]              list_length;

    modport source (output valid, status, read_value, list_length, input ready);
    modport sink   (input valid, status, read_value, list_length, output ready);
endinterface

/* hdl/ilid_cell.sv */
module ilid_cell #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0
) (
    input  logic                               i_clk,
    input  ilid_pkg::t_shift_cmd               i_shift,
    input  ilid_pkg::t_query                   i_query,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  logic signed [ilid_pkg::DATA_W-1:0] i_left_data,
    input  logic signed [ilid_pkg::DATA_W-1:0] i_right_data,
    output logic signed [ilid_pkg::DATA_W-1:0] o_data,
    input  ilid_pkg::t_sweep                   i_sweep,
    output ilid_pkg::t_sweep                   o_sweep
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int CMP_W = ((CNT_W > ilid_pkg::POS_W) ? CNT_W : ilid_pkg::POS_W) + 1;
    localparam logic [CMP_W-1:0] K = CMP_W'(INDEX);

    logic signed [ilid_pkg::DATA_W-1:0] r_data, n_data;
    ilid_pkg::t_sweep                   r_sweep, n_sweep;
    logic [CMP_W-1:0]                   w_sp, w_qp, w_cnt;

    assign w_sp  = CMP_W'(i_shift.p0);
    assign w_qp  = CMP_W'(i_query.p0);
    assign w_cnt = CMP_W'(i_count);

    // Entry: on insert take the left neighbour above the position and the new value at it; on delete the right one
    always_comb begin
        n_data = r_data;
        if (i_shift.ins && (K > w_sp)) begin
            n_data = i_left_data;
        end else if (i_shift.ins && (K == w_sp)) begin
            n_data = i_shift.value;
        end else if (i_shift.del && (K >= w_sp)) begin
            n_data = i_right_data;
        end
    end

    // Sweep stage: fold this entry into the answer from the left
    always_comb begin
        n_sweep.hit = i_sweep.hit
                    | (i_query.locate && (K < w_cnt) && (r_data == i_query.value));
        n_sweep.rd  = i_sweep.rd;
        if (i_query.get_ok && (K == w_qp)) begin
            n_sweep.rd = i_sweep.rd | r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_sweep <= n_sweep;
    end

    assign o_data  = r_data;
    assign o_sweep = r_sweep;

endmodule

/* hdl/ilid_ctrl.sv */
module ilid_ctrl #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ilid_in_if.sink                       i_item,
    ilid_out_if.source                    o_result,
    output ilid_pkg::t_shift_cmd          o_shift,
    output ilid_pkg::t_query              o_query,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    input  ilid_pkg::t_sweep              i_sweep
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int CMP_W = ((CNT_W > ilid_pkg::POS_W) ? CNT_W : ilid_pkg::POS_W) + 1;
    localparam int SW_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    ilid_pkg::t_state                   r_state, n_state;
    logic [CNT_W-1:0]                   r_count, n_count;
    ilid_pkg::t_query                   r_query, n_query;
    logic                               r_is_sweep, n_is_sweep;
    logic                               r_res_status, n_res_status;
    logic [SW_W-1:0]                    r_sw_cnt, n_sw_cnt;
    logic                               r_o_valid, n_o_valid;
    logic                               r_o_status, n_o_status;
    logic signed [ilid_pkg::DATA_W-1:0] r_o_rd, n_o_rd;
    logic [ilid_pkg::LEN_W-1:0]         r_o_len, n_o_len;

    logic             w_accept;
    logic [CMP_W-1:0] w_pos, w_cnt;
    logic             w_pos_nz, w_ins_ok, w_del_ok, w_get_ok;
    logic [CMP_W-1:0] w_len_ext;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_pos    = CMP_W'(i_item.position);
    assign w_cnt    = CMP_W'(r_count);
    assign w_pos_nz = (i_item.position != '0);
    assign w_len_ext = CMP_W'(r_count);

    // Position checks
    assign w_ins_ok = w_pos_nz && (w_pos <= w_cnt + CMP_W'(1)) && (w_cnt < CMP_W'(CAPACITY));
    assign w_del_ok = w_pos_nz && (w_pos <= w_cnt);
    assign w_get_ok = w_del_ok;

    // Shift command applied by the cells at the accept edge
    always_comb begin
        o_shift.ins   = w_accept && (i_item.mode == ilid_pkg::MODE_INSERT) && w_ins_ok;
        o_shift.del   = w_accept && (i_item.mode == ilid_pkg::MODE_DELETE) && w_del_ok;
        o_shift.p0    = i_item.position - ilid_pkg::POS_W'(1);
        o_shift.value = i_item.value;
    end

    assign i_item.ready = (r_state == ilid_pkg::S_IDLE);
    assign o_query      = r_query;
    assign o_count      = r_count;

    // Next state and result register
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_query      = r_query;
        n_is_sweep   = r_is_sweep;
        n_res_status = r_res_status;
        n_sw_cnt     = r_sw_cnt;
        n_o_valid    = r_o_valid && !o_result.ready;
        n_o_status   = r_o_status;
        n_o_rd       = r_o_rd;
        n_o_len      = r_o_len;
        case (r_state)
            ilid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_query.get_ok = (i_item.mode == ilid_pkg::MODE_GET) && w_get_ok;
                    n_query.locate = (i_item.mode == ilid_pkg::MODE_LOCATE);
                    n_query.p0     = i_item.position - ilid_pkg::POS_W'(1);
                    n_query.value  = i_item.value;
                    n_sw_cnt       = '0;
                    case (i_item.mode)
                        ilid_pkg::MODE_INSERT: begin
                            n_is_sweep   = 1'b0;
                            n_res_status = !w_ins_ok;
                            if (w_ins_ok) begin
                                n_count = r_count + CNT_W'(1);
                            end
                            n_state = ilid_pkg::S_DONE;
                        end
                        ilid_pkg::MODE_DELETE: begin
                            n_is_sweep   = 1'b0;
                            n_res_status = !w_del_ok;
                            if (w_del_ok) begin
                                n_count = r_count - CNT_W'(1);
                            end
                            n_state = ilid_pkg::S_DONE;
                        end
                        default: begin
                            n_is_sweep = 1'b1;
                            n_state    = ilid_pkg::S_SWEEP;
                        end
                    endcase
                end
            end
            ilid_pkg::S_SWEEP: begin
                n_sw_cnt = r_sw_cnt + SW_W'(1);
                if (r_sw_cnt == SW_W'(CAPACITY - 1)) begin
                    n_state = ilid_pkg::S_DONE;
                end
            end
            ilid_pkg::S_DONE: begin
                if (!r_o_valid || o_result.ready) begin
                    n_o_valid = 1'b1;
                    n_o_len   = w_len_ext[ilid_pkg::LEN_W-1:0];
                    if (r_is_sweep) begin
                        n_o_rd = i_sweep.rd;
                        if (r_query.get_ok) begin
                            n_o_status = 1'b0;
                        end else if (r_query.locate) begin
                            n_o_status = !i_sweep.hit;
                        end else begin
                            n_o_status = 1'b1;
                        end
                    end else begin
                        n_o_rd     = '0;
                        n_o_status = r_res_status;
                    end
                    n_state = ilid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ilid_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ilid_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_query      <= n_query;
        r_is_sweep   <= n_is_sweep;
        r_res_status <= n_res_status;
        r_sw_cnt     <= n_sw_cnt;
        r_o_status   <= n_o_status;
        r_o_rd       <= n_o_rd;
        r_o_len      <= n_o_len;
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.status      = r_o_status;
    assign o_result.read_value  = r_o_rd;
    assign o_result.list_length = r_o_len;

endmodule

/* hdl/indexed_list_insert_delete_core.sv */
// Channel    Dir  Payload                                  Handshake
// i_item     in   mode[1:0] position[6:0] value[31:0]      valid / ready
// o_result   out  status read_value[31:0] list_length[6:0] valid / ready
//
// One item at a time. Insert and delete shift every cell in the accept
// cycle; the result goes through the done state to the output register.
// Get and locate sweep a partial answer through the cell chain, one cell a
// cycle, then through the done state to the output register.
// The output register lets the next item in while a result is still waiting.
// Synchronous reset empties the list; the entries themselves are not cleared.
module indexed_list_insert_delete_core #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilid_in_if.sink     i_item,
    ilid_out_if.source  o_result
);

    localparam int CNT_W = $clog2(CAPACITY+1);

    ilid_pkg::t_shift_cmd               w_shift;
    ilid_pkg::t_query                   w_query;
    logic [CNT_W-1:0]                   w_count;
    logic signed [ilid_pkg::DATA_W-1:0] w_data  [CAPACITY];
    logic signed [ilid_pkg::DATA_W-1:0] w_left  [CAPACITY];
    logic signed [ilid_pkg::DATA_W-1:0] w_right [CAPACITY];
    ilid_pkg::t_sweep                   w_sweep [CAPACITY+1];

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .o_shift  (w_shift),
        .o_query  (w_query),
        .o_count  (w_count),
        .i_sweep  (w_sweep[CAPACITY])
    );

    assign w_sweep[0] = '0;

    // Row of cells, each linked to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_data[g+1];
        end

        ilid_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_shift),
            .i_query      (w_query),
            .i_count      (w_count),
            .i_left_data  (w_left[g]),
            .i_right_data (w_right[g]),
            .o_data       (w_data[g]),
            .i_sweep      (w_sweep[g]),
            .o_sweep      (w_sweep[g+1])
        );
    end

endmodule

/* hdl/ilid_checker.sv */
module ilid_checker #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_status,
    input logic signed [ilid_pkg::DATA_W-1:0] i_read_value,
    input logic [ilid_pkg::LEN_W-1:0]         i_list_length
);

    // A held result keeps its valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_read_value)
             && $stable(i_list_length)))
        else $error("result changed while stalled");

    // Only one item in flight: no accept on the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while busy");

    // Length on a valid result never exceeds the capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_list_length) <= 32'(CAPACITY)))
        else $error("list length beyond capacity");

    // A non-zero read value only comes with a successful item
    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_read_value != '0)) |-> !i_status)
        else $error("read value on failed item");

endmodule

bind indexed_list_insert_delete_core ilid_checker #(
    .CAPACITY (CAPACITY)
) u_ilid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_read_value  (o_result.read_value),
    .i_list_length (o_result.list_length)
);
